[rtl/core/tps_pkg.sv]
// Shared types, constants and control codes for the tachometer period and speed block.
`timescale 1ns / 1ps

package tps_pkg;

    localparam int TIMER_WIDTH_DEF = 16;
    localparam int CAP_W           = 16;
    localparam int RELOAD_W        = 16;
    localparam int CLOCK_W         = 32;
    localparam int PPR_W           = 8;
    localparam int PERIOD_W        = 32;
    localparam int RPS_W           = 32;
    localparam int RPM_W           = 38;
    localparam int DIV_W           = PERIOD_W + PPR_W;
    localparam int NUM_W           = RPM_W;
    localparam int CNT_W           = $clog2(NUM_W);
    localparam int CFG_IDX_W       = 2;

    localparam logic [RELOAD_W-1:0] RELOAD_RST = 16'hFFFF;
    localparam logic [CLOCK_W-1:0]  CLOCK_RST  = 32'd50000000;
    localparam logic [PPR_W-1:0]    PPR_RST    = 8'd4;
    localparam logic [NUM_W-1:0]    RPM_FACTOR = 38'd60;
    localparam logic [CNT_W-1:0]    DIV_LAST   = CNT_W'(NUM_W - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RELOAD = 2'd0,
        CFG_CLOCK  = 2'd1,
        CFG_PPR    = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic             func;
        logic [CAP_W-1:0] capture_count;
    } evt_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] period_ticks;
        logic [RPS_W-1:0]    speed_rps;
        logic [RPM_W-1:0]    speed_rpm;
        logic                div_error;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_SCALE,
        ST_RPM,
        ST_RPS_LOAD,
        ST_RPS,
        ST_PUBLISH
    } state_t;

    typedef struct packed {
        logic timeout;
        logic capture;
        logic sum;
        logic scale;
        logic div_load;
        logic div_sel_rps;
        logic div_step;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic div_zero;
        logic div_last;
        logic out_busy;
    } status_t;

endpackage

[rtl/core/tachometer_period_speed.sv]
// Top level of the tachometer period and speed block with configuration registers.
//
// Usage:
//   evt channel (evt_valid/evt_stall/evt) carries one beat per timer event:
//   func 0 is a timeout, func 1 a rising-edge capture with the latched count.
//   res channel (res_valid/res_stall/res) returns one beat per capture with
//   the period in ticks, revolutions per second and per minute, and
//   div_error when the period times pulses per revolution is zero.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes reload value,
//   clock frequency and pulses per revolution; cfg_ready is always high.
// Timing:
//   A capture beat reaches the output register through the period sum,
//   scaling, 38 divider steps for the minute rate, a reload, 38 steps for
//   the second rate and publish; a zero divisor skips both divisions. The
//   next beat is accepted in the cycle after publish; evt_stall stays high
//   until then.
// Reset clears the previous capture, timeout count and period, and loads the
// default configuration. A stalled result is held in the output register;
// the next capture finishes its division and waits there before publishing.
`timescale 1ns / 1ps

module tachometer_period_speed #(
    parameter int TIMER_WIDTH = tps_pkg::TIMER_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          evt_valid,
    output logic                          evt_stall,
    input  tps_pkg::evt_t                 evt,
    output logic                          res_valid,
    input  logic                          res_stall,
    output tps_pkg::res_t                 res,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tps_pkg::CLOCK_W-1:0]   cfg_data
);
    import tps_pkg::*;

    logic [RELOAD_W-1:0] reload_reg;
    logic [CLOCK_W-1:0]  clock_reg;
    logic [PPR_W-1:0]    ppr_reg;
    cmd_t                cmd;
    status_t             status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg <= RELOAD_RST;
            clock_reg  <= CLOCK_RST;
            ppr_reg    <= PPR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RELOAD: reload_reg <= cfg_data[RELOAD_W-1:0];
                CFG_CLOCK:  clock_reg  <= cfg_data;
                CFG_PPR:    ppr_reg    <= cfg_data[PPR_W-1:0];
                default:    ;
            endcase
        end
    end

    tps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_func  (evt.func),
        .evt_stall (evt_stall),
        .status    (status),
        .cmd       (cmd)
    );

    tps_dp #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .evt            (evt),
        .reload_value   (reload_reg),
        .clock_hz       (clock_reg),
        .pulses_per_rev (ppr_reg),
        .res_stall      (res_stall),
        .res_valid      (res_valid),
        .res            (res)
    );

    a_capture_busy: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !evt_stall && evt.func |=> evt_stall)
        else $error("capture beat did not start a busy period");

    a_timeout_free: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !evt_stall && !evt.func |=> !evt_stall)
        else $error("timeout beat blocked the event channel");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(evt_stall))
        else $error("result appeared without a capture in work");

    a_error_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.div_error |-> (res.speed_rps == '0) && (res.speed_rpm == '0))
        else $error("division error with nonzero speed");

endmodule

[rtl/core/tps_ctrl.sv]
// Controller state machine sequencing capture, period, scaling, division and publish.
`timescale 1ns / 1ps

module tps_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             evt_valid,
    input  logic             evt_func,
    output logic             evt_stall,
    input  tps_pkg::status_t status,
    output tps_pkg::cmd_t    cmd
);
    import tps_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        evt_stall  = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                evt_stall = 1'b0;
                if (evt_valid)
                begin
                    if (evt_func)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = ST_SUM;
                    end
                    else
                    begin
                        cmd.timeout = 1'b1;
                    end
                end
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale = 1'b1;
                if (status.div_zero)
                begin
                    state_next = ST_PUBLISH;
                end
                else
                begin
                    cmd.div_load = 1'b1;
                    state_next   = ST_RPM;
                end
            end
            ST_RPM:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_RPS_LOAD;
                end
            end
            ST_RPS_LOAD:
            begin
                cmd.div_load    = 1'b1;
                cmd.div_sel_rps = 1'b1;
                state_next      = ST_RPS;
            end
            ST_RPS:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_PUBLISH;
                end
            end
            ST_PUBLISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/tps_dp.sv]
// Datapath: capture state, period sum, divisor scaling, restoring divider, output register.
`timescale 1ns / 1ps

module tps_dp #(
    parameter int TIMER_WIDTH = tps_pkg::TIMER_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tps_pkg::cmd_t                  cmd,
    output tps_pkg::status_t               status,
    input  tps_pkg::evt_t                  evt,
    input  logic [tps_pkg::RELOAD_W-1:0]   reload_value,
    input  logic [tps_pkg::CLOCK_W-1:0]    clock_hz,
    input  logic [tps_pkg::PPR_W-1:0]      pulses_per_rev,
    input  logic                           res_stall,
    output logic                           res_valid,
    output tps_pkg::res_t                  res
);
    import tps_pkg::*;

    localparam logic [CAP_W-1:0] CAP_MASK =
        (TIMER_WIDTH >= CAP_W) ? {CAP_W{1'b1}} : CAP_W'((64'd1 << TIMER_WIDTH) - 64'd1);
    localparam logic [TIMER_WIDTH-1:0] TC_MAX = {TIMER_WIDTH{1'b1}};

    logic [CAP_W-1:0]       prev_reg;
    logic [TIMER_WIDTH-1:0] tc_reg;
    logic [PERIOD_W-1:0]    period_reg;
    logic                   res_valid_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   sel_rps_reg;

    logic [PERIOD_W-1:0]    prod_reg;
    logic [PERIOD_W-1:0]    diff_reg;
    logic [DIV_W-1:0]       div_reg;
    logic [DIV_W-1:0]       rem_reg;
    logic [NUM_W-1:0]       numq_reg;
    logic [RPS_W-1:0]       rps_reg;
    logic [RPM_W-1:0]       rpm_reg;
    res_t                   res_reg;

    logic [CAP_W-1:0]             cap_m;
    logic [TIMER_WIDTH+RELOAD_W-1:0] prod_full;
    logic [DIV_W:0]               trial;
    logic [DIV_W:0]               trial_sub;
    logic                         qbit;
    logic [DIV_W-1:0]             rem_next;
    logic [NUM_W-1:0]             numq_next;
    logic                         div_zero;

    assign cap_m     = evt.capture_count & CAP_MASK;
    assign prod_full = tc_reg * reload_value;
    assign div_zero  = (period_reg == '0) || (pulses_per_rev == '0);

    assign trial     = {rem_reg, numq_reg[NUM_W-1]};
    assign trial_sub = trial - {1'b0, div_reg};
    assign qbit      = !trial_sub[DIV_W];
    assign rem_next  = qbit ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
    assign numq_next = {numq_reg[NUM_W-2:0], qbit};

    assign status.div_zero = div_zero;
    assign status.div_last = (cnt_reg == DIV_LAST);
    assign status.out_busy = res_valid_reg && res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            tc_reg        <= '0;
            period_reg    <= '0;
            res_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            sel_rps_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.timeout && (tc_reg != TC_MAX))
            begin
                tc_reg <= tc_reg + 1'b1;
            end
            if (cmd.capture)
            begin
                prev_reg <= cap_m;
                tc_reg   <= '0;
            end
            if (cmd.sum)
            begin
                period_reg <= diff_reg + prod_reg;
            end
            if (cmd.div_load)
            begin
                cnt_reg     <= '0;
                sel_rps_reg <= cmd.div_sel_rps;
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.publish)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            prod_reg <= PERIOD_W'(prod_full);
            diff_reg <= PERIOD_W'(prev_reg) - PERIOD_W'(cap_m);
        end
        if (cmd.scale)
        begin
            div_reg <= period_reg * pulses_per_rev;
        end
        if (cmd.div_load)
        begin
            rem_reg <= '0;
            if (cmd.div_sel_rps)
            begin
                numq_reg <= NUM_W'(clock_hz);
            end
            else
            begin
                numq_reg <= NUM_W'(clock_hz) * RPM_FACTOR;
            end
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= rem_next;
            numq_reg <= numq_next;
            if (cnt_reg == DIV_LAST)
            begin
                if (sel_rps_reg)
                begin
                    rps_reg <= RPS_W'(numq_next);
                end
                else
                begin
                    rpm_reg <= numq_next;
                end
            end
        end
        if (cmd.publish)
        begin
            res_reg.period_ticks <= period_reg;
            res_reg.speed_rps    <= div_zero ? '0 : rps_reg;
            res_reg.speed_rpm    <= div_zero ? '0 : rpm_reg;
            res_reg.div_error    <= div_zero;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
